### rtl/anct_pkg.sv
// Package for the active note channel tracker.
// Holds field widths, operation and register codes, and the step and result structs.
// No dependencies.
package anct_pkg;

    localparam int OP_W      = 3;
    localparam int CHAN_W    = 16;
    localparam int NOTE_W    = 7;
    localparam int CTRL_W    = 7;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON    = 3'd0,
        OP_NOTE_OFF   = 3'd1,
        OP_CONTROLLER = 3'd2,
        OP_OTHER      = 3'd3,
        OP_TICK       = 3'd4,
        OP_READ_CLEAR = 3'd5
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALL_SOUND_OFF = 1'b0,
        CFG_ALL_NOTES_OFF = 1'b1
    } cfg_idx_t;

    localparam logic [CTRL_W-1:0] ALL_SOUND_OFF_RESET = 7'd120;
    localparam logic [CTRL_W-1:0] ALL_NOTES_OFF_RESET = 7'd123;

    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [CHAN_W-1:0] chans;
        logic [NOTE_W-1:0] note;
        logic              clear_hit;
    } step_t;

    typedef struct packed {
        logic [CHAN_W-1:0] active;
        logic [CHAN_W-1:0] note_chans;
        logic [CHAN_W-1:0] corrupted;
    } result_t;

endpackage

### rtl/anct_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on anct_pkg for field widths.
interface anct_item_if import anct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [CHAN_W-1:0] channels;
    logic [NOTE_W-1:0] note;
    logic [CTRL_W-1:0] controller_number;

    modport source (output valid, operation, channels, note, controller_number,
                    input ready);
    modport sink   (input valid, operation, channels, note, controller_number,
                    output ready);
endinterface

interface anct_result_if import anct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] active_channels;
    logic [CHAN_W-1:0] note_channels;
    logic [CHAN_W-1:0] corrupted_channels;

    modport source (output valid, active_channels, note_channels, corrupted_channels,
                    input ready);
    modport sink   (input valid, active_channels, note_channels, corrupted_channels,
                    output ready);
endinterface

### rtl/anct_state.sv
// Note table, per-channel note counts and corrupted mask, with the one-step update.
// Depends on anct_pkg; instantiated by active_note_channel_tracker_unit.
module anct_state import anct_pkg::*; #(
    parameter int NUM_NOTES    = 128,
    parameter int NUM_CHANNELS = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  step_t   step,
    output result_t result
);

    localparam int CH_W  = (NUM_CHANNELS < CHAN_W) ? NUM_CHANNELS : CHAN_W;
    localparam int IDX_W = (NUM_NOTES > 1) ? $clog2(NUM_NOTES) : 1;
    localparam int CNT_W = $clog2(NUM_NOTES + 1);

    logic [CH_W-1:0]  note_tab_reg  [NUM_NOTES];
    logic [CH_W-1:0]  note_tab_next [NUM_NOTES];
    logic [CNT_W-1:0] cnt_reg       [CH_W];
    logic [CNT_W-1:0] cnt_next      [CH_W];
    logic [CH_W-1:0]  corr_reg;
    logic [CH_W-1:0]  corr_next;

    logic             note_ok;
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0]  chans;
    logic [CH_W-1:0]  old_entry;
    logic [CH_W-1:0]  new_entry;
    logic [CH_W-1:0]  after_entry;
    logic [CH_W-1:0]  agg_now;
    logic [CH_W-1:0]  agg_after;
    logic             note_we;
    logic             clear_all;

    assign note_ok   = 32'(step.note) < NUM_NOTES;
    assign idx       = step.note[IDX_W-1:0];
    assign chans     = step.chans[CH_W-1:0];
    assign old_entry = note_ok ? note_tab_reg[idx] : '0;

    always_comb
    begin
        new_entry = old_entry;
        note_we   = 1'b0;
        clear_all = 1'b0;
        corr_next = corr_reg;
        if (step.valid)
        begin
            case (step.op)
                OP_NOTE_ON:
                begin
                    new_entry = old_entry | chans;
                    note_we   = note_ok;
                end
                OP_NOTE_OFF:
                begin
                    new_entry = old_entry & ~chans;
                    note_we   = note_ok;
                end
                OP_CONTROLLER: clear_all = step.clear_hit;
                OP_TICK:       corr_next = corr_reg | (agg_now & chans);
                OP_READ_CLEAR: corr_next = '0;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        for (int n = 0; n < NUM_NOTES; n++)
        begin
            if (clear_all)
                note_tab_next[n] = note_tab_reg[n] & ~chans;
            else if (note_we && (idx == IDX_W'(n)))
                note_tab_next[n] = new_entry;
            else
                note_tab_next[n] = note_tab_reg[n];
        end
    end

    // track per channel how many notes hold it; the channel is active while nonzero
    always_comb
    begin
        for (int c = 0; c < CH_W; c++)
        begin
            agg_now[c] = cnt_reg[c] != '0;
            if (clear_all && chans[c])
                cnt_next[c] = '0;
            else if (note_we && new_entry[c] && !old_entry[c])
                cnt_next[c] = cnt_reg[c] + CNT_W'(1);
            else if (note_we && !new_entry[c] && old_entry[c])
                cnt_next[c] = cnt_reg[c] - CNT_W'(1);
            else
                cnt_next[c] = cnt_reg[c];
            agg_after[c] = cnt_next[c] != '0;
        end
    end

    assign after_entry = clear_all ? (old_entry & ~chans) : new_entry;

    assign result.active     = CHAN_W'(agg_after);
    assign result.note_chans = note_ok ? CHAN_W'(after_entry) : '0;
    assign result.corrupted  = (step.op == OP_READ_CLEAR) ? CHAN_W'(corr_reg)
                                                          : CHAN_W'(corr_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NUM_NOTES; n++)
                note_tab_reg[n] <= '0;
            for (int c = 0; c < CH_W; c++)
                cnt_reg[c] <= '0;
            corr_reg <= '0;
        end
        else
        begin
            note_tab_reg <= note_tab_next;
            cnt_reg      <= cnt_next;
            corr_reg     <= corr_next;
        end
    end

endmodule

### rtl/active_note_channel_tracker_unit.sv
// Active note channel tracker: one result per input item, fully pipelined.
// An input register feeds the table update; a result register drives the
// output channel. Each accepted item passes the input register and then the result
// register, where a stall of results can hold it. One item is taken every cycle while
// results are taken, since the note table, per-channel note counts and corrupted mask
// are flip-flops updated in the cycle an item leaves the input register. Clearing controller
// numbers reset to 120 and 123 and are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while no item is in flight, as the block does not enforce it.
// Depends on anct_pkg, anct_if and anct_state.
module active_note_channel_tracker_unit import anct_pkg::*; #(
    parameter int NUM_NOTES    = 128,
    parameter int NUM_CHANNELS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    anct_item_if.sink            items,
    anct_result_if.source        results,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CTRL_W-1:0]    cfg_data
);

    logic [CTRL_W-1:0] sound_off_reg;
    logic [CTRL_W-1:0] notes_off_reg;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    op_t               s1_op_reg;
    logic [CHAN_W-1:0] s1_chans_reg;
    logic [NOTE_W-1:0] s1_note_reg;
    logic [CTRL_W-1:0] s1_ctrl_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_res_reg;

    logic              advance;
    step_t             step;
    result_t           step_res;

    assign advance     = !out_valid_reg || results.ready;
    assign items.ready = !s1_valid_reg || advance;

    assign s1_valid_next  = items.ready ? items.valid : s1_valid_reg;
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    assign step.valid     = s1_valid_reg && advance;
    assign step.op        = s1_op_reg;
    assign step.chans     = s1_chans_reg;
    assign step.note      = s1_note_reg;
    assign step.clear_hit = (s1_ctrl_reg == sound_off_reg) || (s1_ctrl_reg == notes_off_reg);

    anct_state #(
        .NUM_NOTES    (NUM_NOTES),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_off_reg <= ALL_SOUND_OFF_RESET;
            notes_off_reg <= ALL_NOTES_OFF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ALL_SOUND_OFF: sound_off_reg <= cfg_data;
                CFG_ALL_NOTES_OFF: notes_off_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            s1_op_reg    <= op_t'(items.operation);
            s1_chans_reg <= items.channels;
            s1_note_reg  <= items.note;
            s1_ctrl_reg  <= items.controller_number;
        end
        if (step.valid)
            out_res_reg <= step_res;
    end

    assign results.valid              = out_valid_reg;
    assign results.active_channels    = out_res_reg.active;
    assign results.note_channels      = out_res_reg.note_chans;
    assign results.corrupted_channels = out_res_reg.corrupted;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> items.ready)
        else $error("input stalled with empty result register");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready) |=> s1_valid_reg)
        else $error("accepted item lost from input register");

    a_step_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        step.valid |=> out_valid_reg)
        else $error("processed item produced no result");

endmodule

### verif/anct_tracker_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the active note channel tracker: tracks the note table, the corrupted
// mask and the clearing numbers, predicts one result per accepted item and compares.
// Depends on anct_pkg and the anct_item_if / anct_result_if interfaces.
module anct_tracker_checker import anct_pkg::*; #(
    parameter int NUM_NOTES    = 128,
    parameter int NUM_CHANNELS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    anct_item_if                 items,
    anct_result_if               results,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CTRL_W-1:0]    cfg_data,
    output int                   mismatches,
    output int                   pending,
    output int                   compared
);

    localparam logic [CHAN_W-1:0] CHAN_KEEP = (NUM_CHANNELS >= CHAN_W) ? {CHAN_W{1'b1}} :
                                              CHAN_W'((64'd1 << NUM_CHANNELS) - 64'd1);

    logic [CHAN_W-1:0] note_masks [NUM_NOTES];
    logic [CHAN_W-1:0] corrupt_mask;
    logic [CTRL_W-1:0] sound_off_num;
    logic [CTRL_W-1:0] notes_off_num;
    result_t           expected_reports [$];
    result_t           want;

    function automatic logic [CHAN_W-1:0] active_union();
        logic [CHAN_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < NUM_NOTES; i++)
            acc |= note_masks[i];
        return acc;
    endfunction

    function automatic result_t track_event(input logic [OP_W-1:0]   op,
                                            input logic [CHAN_W-1:0] chans_in,
                                            input logic [NOTE_W-1:0] note,
                                            input logic [CTRL_W-1:0] ctrl);
        logic [CHAN_W-1:0] chans;
        logic              note_ok;
        result_t           res;
        chans         = chans_in & CHAN_KEEP;
        note_ok       = int'(note) < NUM_NOTES;
        res.corrupted = corrupt_mask;
        case (op)
            OP_NOTE_ON:
                if (note_ok)
                    note_masks[note] |= chans;
            OP_NOTE_OFF:
                if (note_ok)
                    note_masks[note] &= ~chans;
            OP_CONTROLLER:
                if (ctrl == sound_off_num || ctrl == notes_off_num)
                    for (int i = 0; i < NUM_NOTES; i++)
                        note_masks[i] &= ~chans;
            OP_TICK:
                corrupt_mask |= active_union() & chans;
            OP_READ_CLEAR:
                corrupt_mask = '0;
            default:
                ;
        endcase
        if (op != OP_READ_CLEAR)
            res.corrupted = corrupt_mask;
        res.active     = active_union();
        res.note_chans = note_ok ? note_masks[note] : '0;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_NOTES; i++)
                note_masks[i] = '0;
            corrupt_mask  = '0;
            sound_off_num = ALL_SOUND_OFF_RESET;
            notes_off_num = ALL_NOTES_OFF_RESET;
            expected_reports.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ALL_SOUND_OFF: sound_off_num = cfg_data;
                    CFG_ALL_NOTES_OFF: notes_off_num = cfg_data;
                    default:           ;
                endcase
            end
            if (items.valid && items.ready)
                expected_reports.push_back(track_event(items.operation, items.channels,
                                                       items.note, items.controller_number));
            if (results.valid && results.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result active=%h note=%h corrupt=%h", $realtime,
                                 results.active_channels, results.note_channels,
                                 results.corrupted_channels);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compared++;
                    if (want.active !== results.active_channels ||
                        want.note_chans !== results.note_channels ||
                        want.corrupted !== results.corrupted_channels)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch exp active=%h note=%h corrupt=%h",
                                      " got active=%h note=%h corrupt=%h"}, $realtime,
                                     want.active, want.note_chans, want.corrupted,
                                     results.active_channels, results.note_channels,
                                     results.corrupted_channels);
                    end
                end
            end
            pending = expected_reports.size();
        end
    end

endmodule

### verif/tb_active_note_channel_tracker_unit.sv
`timescale 1ns / 1ps
// Testbench top for the active note channel tracker: clock, reset, item and config
// stimulus, random result stalls and the final verdict.
// Depends on anct_pkg, the anct interfaces, the tracker RTL and anct_tracker_checker.
module tb_active_note_channel_tracker_unit;
    import anct_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASES          = 5;
    localparam int IDLE_PERCENT    = 21;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CTRL_W-1:0]    cfg_data;
    int                   mismatches;
    int                   pending;
    int                   compared;
    int                   idle_cycles;
    int                   settings_used;
    int                   op_count [8];
    bit                   calm;
    logic [CTRL_W-1:0]    sound_off_num;
    logic [CTRL_W-1:0]    notes_off_num;
    logic [NOTE_W-1:0]    note_pool [8];

    anct_item_if   items_ch ();
    anct_result_if results_ch ();

    active_note_channel_tracker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_ch),
        .results   (results_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    anct_tracker_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items_ch),
        .results    (results_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .compared   (compared)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        results_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input logic [OP_W-1:0]   op,
                             input logic [CHAN_W-1:0] chans,
                             input logic [NOTE_W-1:0] note,
                             input logic [CTRL_W-1:0] ctrl);
        if (!calm)
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                items_ch.valid <= 1'b0;
                @(negedge clk);
            end
        items_ch.valid             <= 1'b1;
        items_ch.operation         <= op;
        items_ch.channels          <= chans;
        items_ch.note              <= note;
        items_ch.controller_number <= ctrl;
        op_count[op]++;
        do
            @(posedge clk);
        while (!items_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        items_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CTRL_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_clear_numbers(input logic [CTRL_W-1:0] sound_off,
                                     input logic [CTRL_W-1:0] notes_off);
        drain();
        write_reg(CFG_ALL_SOUND_OFF, sound_off);
        write_reg(CFG_ALL_NOTES_OFF, notes_off);
        sound_off_num = sound_off;
        notes_off_num = notes_off;
        settings_used++;
    endtask

    function automatic logic [CHAN_W-1:0] pick_chans();
        case ($urandom_range(9))
            0:       return '1;
            1:       return '0;
            2:       return CHAN_W'(1) << $urandom_range(CHAN_W - 1);
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    task automatic send_random_item();
        int                roll;
        logic [OP_W-1:0]   op;
        logic [NOTE_W-1:0] note;
        logic [CTRL_W-1:0] ctrl;
        roll = $urandom_range(99);
        if (roll < 30)
            op = OP_NOTE_ON;
        else if (roll < 55)
            op = OP_NOTE_OFF;
        else if (roll < 68)
            op = OP_CONTROLLER;
        else if (roll < 73)
            op = OP_OTHER;
        else if (roll < 85)
            op = OP_TICK;
        else if (roll < 94)
            op = OP_READ_CLEAR;
        else if (roll < 97)
            op = OP_SPARE_6;
        else
            op = OP_SPARE_7;
        note = ($urandom_range(4) == 0) ? NOTE_W'($urandom) : note_pool[$urandom_range(7)];
        case ($urandom_range(3))
            0:       ctrl = sound_off_num;
            1:       ctrl = notes_off_num;
            default: ctrl = CTRL_W'($urandom);
        endcase
        send_item(op, pick_chans(), note, ctrl);
    endtask

    initial
    begin
        rst_n                      = 1'b0;
        cfg_we                     = 1'b0;
        cfg_index                  = '0;
        cfg_data                   = '0;
        items_ch.valid             = 1'b0;
        items_ch.operation         = '0;
        items_ch.channels          = '0;
        items_ch.note              = '0;
        items_ch.controller_number = '0;
        calm                       = 1'b0;
        idle_cycles                = 0;
        settings_used              = 1;
        sound_off_num              = ALL_SOUND_OFF_RESET;
        notes_off_num              = ALL_NOTES_OFF_RESET;
        foreach (op_count[i])
            op_count[i] = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(OP_NOTE_ON,    16'hFFFF, 7'd0,   7'd0);
        send_item(OP_NOTE_ON,    16'h0001, 7'd127, 7'd0);
        send_item(OP_NOTE_ON,    16'h8000, 7'd60,  7'd127);
        send_item(OP_NOTE_ON,    16'h0000, 7'd61,  7'd0);
        send_item(OP_TICK,       16'hFFFF, 7'd60,  7'd0);
        send_item(OP_READ_CLEAR, 16'h0000, 7'd0,   7'd0);
        send_item(OP_READ_CLEAR, 16'hFFFF, 7'd127, 7'd0);
        send_item(OP_TICK,       16'h00F0, 7'd0,   7'd0);
        send_item(OP_OTHER,      16'hFFFF, 7'd0,   ALL_SOUND_OFF_RESET);
        send_item(OP_SPARE_6,    16'hFFFF, 7'd0,   ALL_SOUND_OFF_RESET);
        send_item(OP_SPARE_7,    16'hFFFF, 7'd127, ALL_NOTES_OFF_RESET);
        send_item(OP_CONTROLLER, 16'h0F0F, 7'd0,   ALL_SOUND_OFF_RESET);
        send_item(OP_CONTROLLER, 16'h00FF, 7'd0,   7'd5);
        send_item(OP_CONTROLLER, 16'hF000, 7'd60,  ALL_NOTES_OFF_RESET);
        send_item(OP_NOTE_OFF,   16'h00FF, 7'd0,   7'd0);
        send_item(OP_NOTE_OFF,   16'hFFFF, 7'd127, 7'd0);
        send_item(OP_NOTE_OFF,   16'h0001, 7'd100, 7'd0);
        send_item(OP_NOTE_ON,    16'hAAAA, 7'd85,  7'd0);
        send_item(OP_NOTE_ON,    16'h5555, 7'd42,  7'd127);
        send_item(OP_TICK,       16'h0F0F, 7'd42,  7'd0);
        send_item(OP_READ_CLEAR, 16'h0000, 7'd85,  7'd0);
        send_item(OP_CONTROLLER, 16'hFFFF, 7'd85,  7'd127);
        send_item(OP_CONTROLLER, 16'hFFFF, 7'd85,  ALL_NOTES_OFF_RESET);
        send_item(OP_TICK,       16'hFFFF, 7'd85,  7'd0);
        send_item(OP_READ_CLEAR, 16'h0000, 7'd42,  7'd0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       set_clear_numbers(7'd0, 7'd127);
                1:       set_clear_numbers(7'd127, 7'd0);
                2:       set_clear_numbers(7'd64, 7'd64);
                3:       set_clear_numbers(CTRL_W'($urandom), CTRL_W'($urandom));
                default: set_clear_numbers(ALL_SOUND_OFF_RESET, ALL_NOTES_OFF_RESET);
            endcase
            foreach (note_pool[i])
                note_pool[i] = NOTE_W'($urandom);
            calm = (phase == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_item();
            calm = 1'b0;
        end
        drain();

        $display("Covered %0d note on, %0d note off, %0d controller, %0d tick, %0d read-clear, %0d ignored items",
                 op_count[OP_NOTE_ON], op_count[OP_NOTE_OFF], op_count[OP_CONTROLLER],
                 op_count[OP_TICK], op_count[OP_READ_CLEAR],
                 op_count[OP_OTHER] + op_count[OP_SPARE_6] + op_count[OP_SPARE_7]);
        $display("Compared %0d results across %0d clearing-number settings",
                 compared, settings_used);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
rtl/anct_pkg.sv
rtl/anct_if.sv
rtl/anct_state.sv
rtl/active_note_channel_tracker_unit.sv
verif/anct_tracker_checker.sv
verif/tb_active_note_channel_tracker_unit.sv
